@@ src/ialu_pkg.sv @@
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared constants, opcodes and the pipeline word type of the integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

	localparam int DataW  = 32;
	localparam int NCells = DataW;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_SDIV = 5'd3;
	localparam logic [4:0] OP_SREM = 5'd4;
	localparam logic [4:0] OP_SHL  = 5'd5;
	localparam logic [4:0] OP_LSHR = 5'd6;
	localparam logic [4:0] OP_ASHR = 5'd7;
	localparam logic [4:0] OP_AND  = 5'd8;
	localparam logic [4:0] OP_OR   = 5'd9;
	localparam logic [4:0] OP_XOR  = 5'd10;
	localparam logic [4:0] OP_EQ   = 5'd11;
	localparam logic [4:0] OP_NE   = 5'd12;
	localparam logic [4:0] OP_SGT  = 5'd13;
	localparam logic [4:0] OP_SGE  = 5'd14;
	localparam logic [4:0] OP_SLE  = 5'd15;
	localparam logic [4:0] OP_SLT  = 5'd16;
	localparam logic [4:0] OP_UGE  = 5'd17;
	localparam logic [4:0] OP_ULE  = 5'd18;
	localparam logic [4:0] OP_ULT  = 5'd19;
	localparam logic [4:0] OP_UGT  = 5'd20;

	// One word travelling down the divider chain.
	typedef struct packed {
		logic             vld;
		logic [4:0]       kind;
		logic             ok;
		logic             dz;
		logic             special;
		logic             neg_q;
		logic             neg_r;
		logic [DataW-1:0] res;
		logic [DataW-1:0] quo;
		logic [DataW-1:0] rem;
		logic [DataW-1:0] dvs;
	} stage_t;

endpackage

@@ src/ialu_req_if.sv @@
// ----------------------------------------------------------------------------
// ialu_req_if
// Request channel: opcode and two operands.
// ----------------------------------------------------------------------------
interface ialu_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source (output valid, kind, operand_a, operand_b, input ready);
	modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

@@ src/ialu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ialu_rsp_if
// Response channel: result word and flags.
// ----------------------------------------------------------------------------
interface ialu_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               result_valid;
	logic               divide_by_zero;

	modport source (output valid, result_value, result_valid, divide_by_zero, input ready);
	modport sink   (input valid, result_value, result_valid, divide_by_zero, output ready);
endinterface

@@ src/ialu_front.sv @@
// ----------------------------------------------------------------------------
// ialu_front
// Decode stage: computes every non-divide result and prepares the divider.
// ----------------------------------------------------------------------------
module ialu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  logic [4:0]           kind,
	input  logic [31:0]          a,
	input  logic [31:0]          b,
	output ialu_pkg::stage_t     st_s1
);

	ialu_pkg::stage_t nxt;
	logic [4:0]       sh;
	logic [31:0]      prod;
	logic             is_div;

	assign sh     = b[4:0];
	assign prod   = a * b;
	assign is_div = (kind == ialu_pkg::OP_SDIV) || (kind == ialu_pkg::OP_SREM);

	// Result selection for the non-divide operations, the divide special cases and divide set-up.
	always_comb begin
		nxt         = '0;
		nxt.vld     = vld;
		nxt.kind    = kind;
		nxt.ok      = 1'b1;
		nxt.neg_q   = a[31] ^ b[31];
		nxt.neg_r   = a[31];
		nxt.quo     = a[31] ? (32'd0 - a) : a;
		nxt.dvs     = b[31] ? (32'd0 - b) : b;
		nxt.special = 1'b1;
		unique case (kind)
			ialu_pkg::OP_ADD:  nxt.res = a + b;
			ialu_pkg::OP_SUB:  nxt.res = a - b;
			ialu_pkg::OP_MUL:  nxt.res = prod[31:0];
			ialu_pkg::OP_SDIV,
			ialu_pkg::OP_SREM: begin
				if (b == 32'd0) begin
					nxt.dz  = 1'b1;
					nxt.res = (kind == ialu_pkg::OP_SDIV) ? 32'hFFFF_FFFF : a;
				end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
					nxt.res = (kind == ialu_pkg::OP_SDIV) ? 32'h8000_0000 : 32'd0;
				end else begin
					nxt.special = 1'b0;
				end
			end
			ialu_pkg::OP_SHL:  nxt.res = a << sh;
			ialu_pkg::OP_LSHR: nxt.res = a >> sh;
			ialu_pkg::OP_ASHR: nxt.res = $unsigned($signed(a) >>> sh);
			ialu_pkg::OP_AND:  nxt.res = a & b;
			ialu_pkg::OP_OR:   nxt.res = a | b;
			ialu_pkg::OP_XOR:  nxt.res = a ^ b;
			ialu_pkg::OP_EQ:   nxt.res = {31'd0, a == b};
			ialu_pkg::OP_NE:   nxt.res = {31'd0, a != b};
			ialu_pkg::OP_SGT:  nxt.res = {31'd0, $signed(a) > $signed(b)};
			ialu_pkg::OP_SGE:  nxt.res = {31'd0, $signed(a) >= $signed(b)};
			ialu_pkg::OP_SLE:  nxt.res = {31'd0, $signed(a) <= $signed(b)};
			ialu_pkg::OP_SLT:  nxt.res = {31'd0, $signed(a) < $signed(b)};
			ialu_pkg::OP_UGE:  nxt.res = {31'd0, a >= b};
			ialu_pkg::OP_ULE:  nxt.res = {31'd0, a <= b};
			ialu_pkg::OP_ULT:  nxt.res = {31'd0, a < b};
			ialu_pkg::OP_UGT:  nxt.res = {31'd0, a > b};
			default:           nxt.ok  = 1'b0;
		endcase
		if (!is_div) begin
			nxt.special = 1'b1;
		end
	end

	// Stage register, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (en) begin
			st_s1 <= nxt;
		end
	end

endmodule

@@ src/ialu_cell.sv @@
// ----------------------------------------------------------------------------
// ialu_cell
// One restoring-division cell: develops one quotient bit and passes the word on.
// ----------------------------------------------------------------------------
module ialu_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ialu_pkg::stage_t st_d,
	output ialu_pkg::stage_t st_q
);

	logic [32:0]      shifted;
	logic [32:0]      trial;
	logic             fits;
	ialu_pkg::stage_t nxt;

	// Shift in the next dividend bit and try to subtract the divisor.
	assign shifted = {st_d.rem, st_d.quo[31]};
	assign trial   = shifted - {1'b0, st_d.dvs};
	assign fits    = !trial[32];

	// The word moves on unchanged apart from the partial remainder and quotient.
	always_comb begin
		nxt     = st_d;
		nxt.rem = fits ? trial[31:0] : shifted[31:0];
		nxt.quo = {st_d.quo[30:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= nxt;
		end
	end

endmodule

@@ src/int32_alu_with_compare_unit.sv @@
// ----------------------------------------------------------------------------
// int32_alu_with_compare_unit
// 32-bit integer ALU with pipelined signed divide and compares.
// ----------------------------------------------------------------------------
//  Port   Dir   Carries
//  req    sink  kind, operand_a, operand_b
//  rsp    src   result_value, result_valid, divide_by_zero
//
//  One word is accepted per cycle while the response side is not stalled; each passes
//  a decode stage, a chain of 32 division cells and an output register.
//  The divider cell chain sets the latency; every operation travels through it.
//  Reset clears the occupancy bits of all stages and the output register.
//  A stalled response freezes the whole chain and drops req.ready.
// ----------------------------------------------------------------------------
module int32_alu_with_compare_unit (
	input  logic       clk,
	input  logic       arst_n,
	ialu_req_if.sink   req,
	ialu_rsp_if.source rsp
);

	logic             en;
	logic             out_vld_q;
	logic [31:0]      out_val_q;
	logic             out_ok_q;
	logic             out_dz_q;
	ialu_pkg::stage_t chain [ialu_pkg::NCells+1];
	logic [31:0]      fin;

	// The chain advances whenever the output register can take a word.
	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;

	ialu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (req.valid),
		.kind   (req.kind),
		.a      (req.operand_a),
		.b      (req.operand_b),
		.st_s1  (chain[0])
	);

	for (genvar i = 0; i < ialu_pkg::NCells; i++) begin : g_cell
		ialu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.st_d   (chain[i]),
			.st_q   (chain[i+1])
		);
	end

	// Sign correction of the quotient or remainder.
	always_comb begin
		fin = chain[ialu_pkg::NCells].res;
		if (!chain[ialu_pkg::NCells].special) begin
			if (chain[ialu_pkg::NCells].kind == ialu_pkg::OP_SDIV) begin
				fin = chain[ialu_pkg::NCells].neg_q ? (32'd0 - chain[ialu_pkg::NCells].quo)
					: chain[ialu_pkg::NCells].quo;
			end else begin
				fin = chain[ialu_pkg::NCells].neg_r ? (32'd0 - chain[ialu_pkg::NCells].rem)
					: chain[ialu_pkg::NCells].rem;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= chain[ialu_pkg::NCells].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_val_q <= fin;
			out_ok_q  <= chain[ialu_pkg::NCells].ok;
			out_dz_q  <= chain[ialu_pkg::NCells].dz;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.result_value   = out_val_q;
	assign rsp.result_valid   = out_ok_q;
	assign rsp.divide_by_zero = out_dz_q;

endmodule

@@ src/ialu_checker.sv @@
// ----------------------------------------------------------------------------
// ialu_checker
// Port-level checks of the integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
module ialu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_value,
	input logic        rsp_ok,
	input logic        rsp_dz
);

	// A stalled response word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_dz))
		else $error("response word changed while stalled");

	// Requests are only refused while the response side stalls.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without a stall");

	// The divide flag belongs to a supported opcode.
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_dz |-> rsp_ok)
		else $error("divide flag on unsupported opcode");

	// Unsupported opcodes give a zero result.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_value == 32'd0)
		else $error("non-zero result for unsupported opcode");

endmodule

bind int32_alu_with_compare_unit ialu_checker u_ialu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.result_value),
	.rsp_ok    (rsp.result_valid),
	.rsp_dz    (rsp.divide_by_zero)
);

@@ bench/int32_alu_with_compare_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int32_alu_with_compare_unit_test
// Drives opcode and operand words into the ALU with random bursts and gaps,
// stalls the response channel on its own pattern, and compares every result
// word with a predicted one held in order of acceptance.
// ----------------------------------------------------------------------------

// Scoreboard: predicts each ALU result and keeps the outstanding ones in order.
class alu_scoreboard;
	typedef struct packed {
		logic [31:0] value;
		logic        vld;
		logic        dz;
	} alu_result_t;

	alu_result_t pending[$];
	int          errors;
	int          checked;

	function alu_result_t compute(logic [4:0] op, logic [31:0] a, logic [31:0] b);
		alu_result_t r;
		logic [31:0] ma, mb, q, m;
		logic signed [31:0] sa, sb;
		r.value = '0;
		r.vld = 1'b1;
		r.dz = 1'b0;
		sa = a;
		sb = b;
		case (op)
			ialu_pkg::OP_ADD: r.value = a + b;
			ialu_pkg::OP_SUB: r.value = a - b;
			ialu_pkg::OP_MUL: r.value = a * b;
			ialu_pkg::OP_SDIV, ialu_pkg::OP_SREM: begin
				if (b == 32'd0) begin
					r.dz = 1'b1;
					r.value = (op == ialu_pkg::OP_SDIV) ? 32'hFFFF_FFFF : a;
				end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
					r.value = (op == ialu_pkg::OP_SDIV) ? 32'h8000_0000 : 32'd0;
				end else begin
					ma = a[31] ? -a : a;
					mb = b[31] ? -b : b;
					q = ma / mb;
					m = ma % mb;
					if (op == ialu_pkg::OP_SDIV)
						r.value = (a[31] ^ b[31]) ? -q : q;
					else
						r.value = a[31] ? -m : m;
				end
			end
			ialu_pkg::OP_SHL:  r.value = a << b[4:0];
			ialu_pkg::OP_LSHR: r.value = a >> b[4:0];
			ialu_pkg::OP_ASHR: r.value = sa >>> b[4:0];
			ialu_pkg::OP_AND:  r.value = a & b;
			ialu_pkg::OP_OR:   r.value = a | b;
			ialu_pkg::OP_XOR:  r.value = a ^ b;
			ialu_pkg::OP_EQ:   r.value = {31'd0, a == b};
			ialu_pkg::OP_NE:   r.value = {31'd0, a != b};
			ialu_pkg::OP_SGT:  r.value = {31'd0, sa > sb};
			ialu_pkg::OP_SGE:  r.value = {31'd0, sa >= sb};
			ialu_pkg::OP_SLE:  r.value = {31'd0, sa <= sb};
			ialu_pkg::OP_SLT:  r.value = {31'd0, sa < sb};
			ialu_pkg::OP_UGE:  r.value = {31'd0, a >= b};
			ialu_pkg::OP_ULE:  r.value = {31'd0, a <= b};
			ialu_pkg::OP_ULT:  r.value = {31'd0, a < b};
			ialu_pkg::OP_UGT:  r.value = {31'd0, a > b};
			default: r.vld = 1'b0;
		endcase
		return r;
	endfunction

	function void note_request(logic [4:0] op, logic [31:0] a, logic [31:0] b);
		pending.push_back(compute(op, a, b));
	endfunction

	function void check_result(logic [31:0] value, logic vld, logic dz);
		alu_result_t e;
		checked++;
		if (pending.size() == 0) begin
			$error("result word with nothing expected: value %h", value);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (value !== e.value) begin
			$error("result_value: expected %h, got %h", e.value, value);
			errors++;
		end
		if (vld !== e.vld) begin
			$error("result_valid: expected %b, got %b", e.vld, vld);
			errors++;
		end
		if (dz !== e.dz) begin
			$error("divide_by_zero: expected %b, got %b", e.dz, dz);
			errors++;
		end
	endfunction
endclass

module int32_alu_with_compare_unit_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic gaps_on = 1'b1;
	logic stalls_on = 1'b1;
	int   sent;

	ialu_req_if req ();
	ialu_rsp_if rsp ();

	alu_scoreboard board = new();

	int32_alu_with_compare_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.kind = '0;
		req.operand_a = '0;
		req.operand_b = '0;
		rsp.ready = 1'b0;
	end

	// Accepted words on either side go to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			board.note_request(req.kind, req.operand_a, req.operand_b);
		if (arst_n && rsp.valid && rsp.ready)
			board.check_result(rsp.result_value, rsp.result_valid, rsp.divide_by_zero);
	end

	// Receiver stall pattern: runs of ready and not ready of random length.
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 12);
			repeat (run) begin
				@(posedge clk);
				rsp.ready <= 1'b1;
			end
			if (stalls_on) begin
				run = $urandom_range(0, 6);
				repeat (run) begin
					@(posedge clk);
					rsp.ready <= 1'b0;
				end
			end
		end
	end

	// Presents one word and holds it until it is accepted.
	task automatic send_word(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b);
		req.valid <= 1'b1;
		req.kind <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	// Sender gap between bursts.
	task automatic pause_sender();
		int gap;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4: return 32'd1;
			5: return $urandom_range(0, 40) - 20;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [4:0]  op;
		logic [31:0] a, b;
		int          burst, wait_cycles;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: extremes and special cases of the divider and shifts.
		send_word(ialu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
		send_word(ialu_pkg::OP_SUB, 32'h8000_0000, 32'd1);
		send_word(ialu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h8000_0000);
		send_word(ialu_pkg::OP_SDIV, 32'd77, 32'd0);
		send_word(ialu_pkg::OP_SREM, 32'h8000_0001, 32'd0);
		send_word(ialu_pkg::OP_SDIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(ialu_pkg::OP_SREM, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(ialu_pkg::OP_SDIV, -32'sd7, 32'd2);
		send_word(ialu_pkg::OP_SREM, -32'sd7, 32'd2);
		send_word(ialu_pkg::OP_SHL, 32'hFFFF_FFFF, 32'hFFFF_FFE1);
		send_word(ialu_pkg::OP_LSHR, 32'h8000_0000, 32'd31);
		send_word(ialu_pkg::OP_ASHR, 32'h8000_0000, 32'd31);
		send_word(ialu_pkg::OP_ASHR, 32'h8000_0000, 32'd32);
		send_word(ialu_pkg::OP_AND, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
		send_word(ialu_pkg::OP_OR, 32'd0, 32'hA5A5_5A5A);
		send_word(ialu_pkg::OP_XOR, 32'hFFFF_FFFF, 32'h0);
		for (int k = ialu_pkg::OP_EQ; k <= ialu_pkg::OP_UGT; k++)
			send_word(k[4:0], 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(5'd21, 32'd3, 32'd4);
		send_word(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Random words in bursts; a stretch in the middle runs with no idling.
		while (sent < 430) begin
			burst = $urandom_range(1, 16);
			gaps_on = !(sent > 180 && sent < 260);
			stalls_on = gaps_on;
			repeat (burst) begin
				op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(21, 31))
				                                 : 5'($urandom_range(0, 20));
				a = pick_operand();
				b = pick_operand();
				send_word(op, a, b);
			end
			pause_sender();
		end
		req.valid <= 1'b0;

		// Drain: wait for outstanding results, then let the pipeline settle.
		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);

		$display("Sent %0d words over all 32 opcodes, checked %0d result words,", sent,
			board.checked);
		$display("including zero divisors, most-negative by minus one and wide shifts.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Safety limit far beyond the slowest correct run.
	initial begin
		#200000;
		$display("tb: failure");
		$finish;
	end
endmodule

@@ sim.f @@
src/ialu_pkg.sv
src/ialu_req_if.sv
src/ialu_rsp_if.sv
src/ialu_front.sv
src/ialu_cell.sv
src/int32_alu_with_compare_unit.sv
src/ialu_checker.sv
bench/int32_alu_with_compare_unit_test.sv
